// File: rtl/hcbd_pkg.sv
package hcbd_pkg;

	localparam int unsigned MAX_SIZE_LINE = 8;
	localparam int unsigned LINE_W = 4;
	localparam int unsigned SIZE_W = 32;
	localparam int unsigned DIGIT_W = 4;
	localparam logic [SIZE_W-1:0] MAX_CHUNK_RESET = 32'd16777216;
	localparam logic [DIGIT_W-1:0] DIGIT_SAT = 4'd15;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_SEMI = 8'h3b;

	typedef enum logic [2:0] {
		PH_SIZE     = 3'd0,
		PH_BODY     = 3'd1,
		PH_TRAIL    = 3'd2,
		PH_TRAIL_LF = 3'd3,
		PH_DONE     = 3'd4,
		PH_ERROR    = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_FRAME   = 3'd0,
		ST_BODY    = 3'd1,
		ST_DONE    = 3'd2,
		ST_ERROR   = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef struct packed {
		phase_t              phase;
		logic                cr_pending;
		logic [LINE_W-1:0]   line_length;
		logic                in_extension;
		logic [DIGIT_W-1:0]  digit_count;
		logic [SIZE_W-1:0]   size_acc;
		logic [SIZE_W-1:0]   bytes_remaining;
	} hcbd_state_t;

	localparam hcbd_state_t STATE_RESET = '{
		phase:           PH_SIZE,
		cr_pending:      1'b0,
		line_length:     '0,
		in_extension:    1'b0,
		digit_count:     '0,
		size_acc:        '0,
		bytes_remaining: '0
	};

endpackage

// File: rtl/hcbd_step.sv
module hcbd_step (
	input  hcbd_pkg::hcbd_state_t         cur,
	input  logic [7:0]                    in_byte,
	input  logic                          restart,
	input  logic [hcbd_pkg::SIZE_W-1:0]   max_chunk_size,
	output hcbd_pkg::hcbd_state_t         nxt,
	output hcbd_pkg::status_t             status,
	output logic [7:0]                    body_byte
);
	import hcbd_pkg::*;

	localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(MAX_SIZE_LINE);

	hcbd_state_t        s;
	hcbd_state_t        n;
	status_t            st;
	logic [7:0]         body;
	logic               is_hex;
	logic [3:0]         hex_val;
	logic               go_on;
	logic [LINE_W-1:0]  ll;
	logic [SIZE_W-1:0]  rem_dec;

	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_val = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			hex_val = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			hex_val = 4'(in_byte - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	always_comb begin
		s       = restart ? STATE_RESET : cur;
		n       = s;
		st      = ST_FRAME;
		body    = 8'd0;
		go_on   = 1'b1;
		ll      = s.line_length;
		rem_dec = s.bytes_remaining - SIZE_W'(1);
		unique case (s.phase)
			PH_SIZE: begin
				if (s.cr_pending) begin
					n.cr_pending = 1'b0;
					go_on = 1'b0;
					if (in_byte == CH_LF) begin
						if (s.line_length == '0 || s.digit_count == '0 ||
							s.size_acc > max_chunk_size) begin
							n.phase = PH_ERROR;
							st = ST_ERROR;
						end else begin
							n = STATE_RESET;
							if (s.size_acc == '0) begin
								n.phase = PH_DONE;
								st = ST_DONE;
							end else begin
								n.phase = PH_BODY;
								n.bytes_remaining = s.size_acc;
							end
						end
					end else if (!s.in_extension || ll == LINE_MAX) begin
						n.phase = PH_ERROR;
						st = ST_ERROR;
					end else begin
						ll = ll + LINE_W'(1);
						n.line_length = ll;
						go_on = 1'b1;
					end
				end
				if (go_on) begin
					if (in_byte == CH_CR) begin
						n.cr_pending = 1'b1;
					end else if (ll == LINE_MAX) begin
						n.phase = PH_ERROR;
						st = ST_ERROR;
					end else begin
						n.line_length = ll + LINE_W'(1);
						if (s.in_extension) begin
							st = ST_FRAME;
						end else if (in_byte == CH_SEMI) begin
							if (s.digit_count == '0) begin
								n.phase = PH_ERROR;
								st = ST_ERROR;
							end else begin
								n.in_extension = 1'b1;
							end
						end else if (!is_hex || s.size_acc[SIZE_W-1 -: 4] != 4'd0) begin
							n.phase = PH_ERROR;
							st = ST_ERROR;
						end else begin
							n.size_acc = {s.size_acc[SIZE_W-5:0], hex_val};
							if (s.digit_count != DIGIT_SAT) begin
								n.digit_count = s.digit_count + DIGIT_W'(1);
							end
						end
					end
				end
			end
			PH_BODY: begin
				st = ST_BODY;
				body = in_byte;
				if (s.bytes_remaining == '0 || rem_dec == '0) begin
					n.bytes_remaining = '0;
					n.phase = PH_TRAIL;
				end else begin
					n.bytes_remaining = rem_dec;
				end
			end
			PH_TRAIL: begin
				if (in_byte == CH_CR) begin
					n.phase = PH_TRAIL_LF;
				end else if (in_byte == CH_LF) begin
					n = STATE_RESET;
					n.bytes_remaining = s.bytes_remaining;
				end else begin
					n.phase = PH_ERROR;
					st = ST_ERROR;
				end
			end
			PH_TRAIL_LF: begin
				if (in_byte == CH_LF) begin
					n = STATE_RESET;
					n.bytes_remaining = s.bytes_remaining;
				end else begin
					n.phase = PH_ERROR;
					st = ST_ERROR;
				end
			end
			PH_DONE: begin
				st = ST_IGNORED;
			end
			default: begin
				n.phase = PH_ERROR;
				st = ST_ERROR;
			end
		endcase
		nxt       = n;
		status    = st;
		body_byte = body;
	end

endmodule

// File: rtl/http_chunked_body_decoder.sv
// Byte-serial HTTP/1.1 chunked body deframer. Each accepted byte yields exactly one result
// word (status plus body byte) through the input register and then the result register;
// a new byte is taken every cycle unless the output stalls, since the parser state is
// updated as a byte passes from the input register to the result register. max_chunk_size
// is written through cfg_valid/cfg_ready (always ready) and must only be changed while the
// decoder is idle. Completion and error are sticky until a byte arrives with restart set.
module http_chunked_body_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  in_byte,
	input  logic                        restart,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  status,
	output logic [7:0]                  body_byte,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [hcbd_pkg::SIZE_W-1:0] cfg_data
);
	import hcbd_pkg::*;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                restart_s1;
	logic                valid_s2;
	status_t             status_s2;
	logic [7:0]          body_s2;
	logic [SIZE_W-1:0]   max_chunk_q;
	hcbd_state_t         state_q;
	hcbd_state_t         state_nxt;
	status_t             step_status;
	logic [7:0]          step_body;
	logic                adv;
	logic                take_in;

	assign adv       = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !adv;
	assign take_in   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	hcbd_step u_step (
		.cur            (state_q),
		.in_byte        (byte_s1),
		.restart        (restart_s1),
		.max_chunk_size (max_chunk_q),
		.nxt            (state_nxt),
		.status         (step_status),
		.body_byte      (step_body)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			state_q     <= STATE_RESET;
			max_chunk_q <= MAX_CHUNK_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_chunk_q <= cfg_data;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1    <= in_byte;
			restart_s1 <= restart;
		end
		if (adv && valid_s1) begin
			status_s2 <= step_status;
			body_s2   <= step_body;
		end
	end

	assign out_valid = valid_s2;
	assign status    = 3'(status_s2);
	assign body_byte = body_s2;

endmodule
